/* hw/rtl/gwja_pkg.sv */
// Shared types, codes and reset values for the greedy weighted job assigner.
`default_nettype none
package gwja_pkg;

    localparam int DefMaxAgents = 32;

    // Input opcodes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CAP   = 2'd1;
    localparam logic [1:0] OP_ENTRY = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WC  = 2'd0;
    localparam logic [1:0] REG_WR  = 2'd1;
    localparam logic [1:0] REG_NAG = 2'd2;

    localparam logic [7:0] RST_WC  = 8'd1;
    localparam logic [7:0] RST_WR  = 8'd1;
    localparam logic [5:0] RST_NAG = 6'd8;

    typedef struct packed {
        logic [7:0] wc;
        logic [7:0] wr;
        logic [5:0] nag;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  agent;
        logic [19:0] cap;
        logic [15:0] cost;
        logic [15:0] res;
    } t_cmd;

    // Packed with the job number in the lowest bits.
    typedef struct packed {
        logic [31:0] final_cost;
        logic        every;
        logic [31:0] total;
        logic [4:0]  chosen;
        logic        assigned;
        logic [15:0] job;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/greedy_weighted_job_agent_assign.sv */
// Top level of the greedy weighted job assigner: ports, registers, result buffer.
//
// Channel   Dir  Handshake                  Content
// s_axis    in   tvalid/tready              one opcode transaction
// m_axis    out  tvalid/tready              one decided job
// apb       in   psel/penable/pwrite/pready weights and agent count
//
// Capacity loads, problem starts and non-final job entries leave the engine idle.
// The entry for the last agent in use starts the decision: a scoring pass that
// reads each agent's entry and writes its score, then a sort over the position
// buffer whose outer passes each read, compare down the buffer and write back,
// then a scan that reads, picks and checks each agent tried, then the hand-off
// of the result to the output register, which waits while that register is full.
// Reset is synchronous, active low; it clears capacities, usage and totals.
// A stalled result waits in the output register while the next job's entries
// are taken; the engine holds its finished result only if that register is full.
`default_nettype none
module greedy_weighted_job_agent_assign #(
    parameter int MAX_AGENTS = gwja_pkg::DefMaxAgents
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] agent_index, [24:5] capacity_value, [40:25] job_cost,
    // [56:41] job_resource, rest zero
    input  wire  [63:0] s_axis_tdata,
    // [1:0] opcode
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] job_number, [16] was_assigned, [21:17] chosen_agent,
    // [53:22] running_total, [54] every_job_placed, [86:55] final_cost, rest zero
    output logic [87:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]         r_wc, r_wr;
    logic [5:0]         r_nag;
    gwja_pkg::t_cfg     w_cfg;
    gwja_pkg::t_cmd     w_cmd;
    gwja_pkg::t_result  w_res, r_out;
    logic               r_out_vld;
    logic               w_idle, w_res_valid, w_res_ready, w_cfg_wr;

    // Configuration registers; the host must write them only while the engine is idle; the block does not enforce this.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc  <= gwja_pkg::RST_WC;
            r_wr  <= gwja_pkg::RST_WR;
            r_nag <= gwja_pkg::RST_NAG;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                gwja_pkg::REG_WC:  r_wc  <= pwdata[7:0];
                gwja_pkg::REG_WR:  r_wr  <= pwdata[7:0];
                gwja_pkg::REG_NAG: r_nag <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gwja_pkg::REG_WC:  prdata = {24'd0, r_wc};
            gwja_pkg::REG_WR:  prdata = {24'd0, r_wr};
            gwja_pkg::REG_NAG: prdata = {26'd0, r_nag};
            default:           prdata = 32'd0;
        endcase
    end

    assign w_cfg.wc  = r_wc;
    assign w_cfg.wr  = r_wr;
    assign w_cfg.nag = r_nag;

    // Unpack the incoming transaction.
    assign w_cmd.op    = s_axis_tuser;
    assign w_cmd.agent = s_axis_tdata[4:0];
    assign w_cmd.cap   = s_axis_tdata[24:5];
    assign w_cmd.cost  = s_axis_tdata[40:25];
    assign w_cmd.res   = s_axis_tdata[56:41];

    assign s_axis_tready = w_idle;

    gwja_core #(
        .MAX_AGENTS (MAX_AGENTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Output register: frees the engine as soon as a result is parked here.
    assign w_res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_out_vld <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out};

endmodule
`default_nettype wire

/* hw/rtl/gwja_core.sv */
// Memory-based engine: entry buffer, scoring pass, exchange sort and feasibility scan.
`default_nettype none
module gwja_core #(
    parameter int MAX_AGENTS = gwja_pkg::DefMaxAgents
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire gwja_pkg::t_cfg i_cfg,
    input  wire                 i_cmd_valid,
    input  wire gwja_pkg::t_cmd i_cmd,
    output logic                o_idle,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output gwja_pkg::t_result   o_res
);

    localparam int AW    = $clog2(MAX_AGENTS);
    localparam int NW    = $clog2(MAX_AGENTS + 1);
    localparam int SW    = 25;
    localparam int SRT_W = SW + AW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_JRD  = 4'd1;
    localparam logic [3:0] ST_KRD  = 4'd2;
    localparam logic [3:0] ST_CMP  = 4'd3;
    localparam logic [3:0] ST_JWR  = 4'd4;
    localparam logic [3:0] ST_SRD  = 4'd5;
    localparam logic [3:0] ST_SAG  = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_SCA  = 4'd9;
    localparam logic [3:0] ST_SCW  = 4'd10;

    logic [3:0]        r_state;
    logic [AW-1:0]     r_epos, r_j, r_k, r_i, r_agent;
    logic [SRT_W-1:0]  r_held;
    logic [31:0]       r_total;
    logic              r_all;
    logic [15:0]       r_jobs;
    logic              r_placed;
    logic [4:0]        r_chosen;
    logic [MAX_AGENTS-1:0] r_cap_vld, r_use_vld;

    // Memories and their registered read data.
    logic [SRT_W-1:0] m_srt [MAX_AGENTS];
    logic [31:0]      m_ent [MAX_AGENTS];
    logic [19:0]      m_cap [MAX_AGENTS];
    logic [19:0]      m_use [MAX_AGENTS];
    logic [SRT_W-1:0] r_srt_q;
    logic [31:0]      r_ent_q;
    logic [19:0]      r_cap_q, r_use_q;
    logic             r_capv_q, r_usev_q;

    logic [NW-1:0]    w_n, w_nm1;
    logic [AW-1:0]    w_last;
    logic [23:0]      w_p0, w_p1;
    logic [SW-1:0]    w_score;
    logic             w_cmd_entry, w_cmd_cap, w_cmd_start, w_agent_ok, w_last_entry;
    logic             w_srt_we;
    logic [AW-1:0]    w_srt_waddr, w_srt_raddr, w_sc_addr, w_ent_raddr;
    logic [SRT_W-1:0] w_srt_wdata;
    logic [19:0]      w_cap_eff, w_use_eff;
    logic [20:0]      w_sum;
    logic             w_fit, w_swap;
    logic [32:0]      w_tot_sum;

    always_comb begin
        if (i_cfg.nag == 6'd0) begin
            w_n = NW'(1);
        end else if (8'(i_cfg.nag) > 8'(MAX_AGENTS)) begin
            w_n = NW'(MAX_AGENTS);
        end else begin
            w_n = NW'(i_cfg.nag);
        end
    end
    assign w_nm1  = w_n - NW'(1);
    assign w_last = w_nm1[AW-1:0];

    // Scores are formed from the stored entries with the weights in force at
    // decision time.
    assign w_p0    = 24'(i_cfg.wc) * 24'(r_ent_q[31:16]);
    assign w_p1    = 24'(i_cfg.wr) * 24'(r_ent_q[15:0]);
    assign w_score = {1'b0, w_p0} + {1'b0, w_p1};

    assign o_idle       = (r_state == ST_IDLE);
    assign w_cmd_entry  = i_cmd_valid && o_idle && (i_cmd.op == gwja_pkg::OP_ENTRY);
    assign w_cmd_cap    = i_cmd_valid && o_idle && (i_cmd.op == gwja_pkg::OP_CAP);
    assign w_cmd_start  = i_cmd_valid && o_idle && (i_cmd.op == gwja_pkg::OP_START);
    assign w_agent_ok   = (8'(i_cmd.agent) < 8'(MAX_AGENTS));
    assign w_last_entry = (NW'(r_epos) >= w_nm1);

    // Later position swaps when its held score is below the one read at k.
    assign w_swap = (r_held[SRT_W-1:AW] < r_srt_q[SRT_W-1:AW]);

    always_comb begin
        w_srt_we    = 1'b0;
        w_srt_waddr = r_k;
        w_srt_wdata = r_held;
        if (r_state == ST_SCW) begin
            w_srt_we    = 1'b1;
            w_srt_waddr = r_i;
            w_srt_wdata = {w_score, r_i};
        end else if (r_state == ST_CMP && w_swap) begin
            w_srt_we    = 1'b1;
            w_srt_waddr = r_k;
        end else if (r_state == ST_JWR) begin
            w_srt_we    = 1'b1;
            w_srt_waddr = r_j;
        end
    end

    always_comb begin
        case (r_state)
            ST_JRD:  w_srt_raddr = r_j;
            ST_KRD:  w_srt_raddr = r_k;
            ST_CMP:  w_srt_raddr = r_k - AW'(1);
            default: w_srt_raddr = r_i;
        endcase
    end

    assign w_sc_addr   = r_srt_q[AW-1:0];
    assign w_ent_raddr = (r_state == ST_SCA) ? r_i : w_sc_addr;

    always_ff @(posedge i_clk) begin
        if (w_srt_we) begin
            m_srt[w_srt_waddr] <= w_srt_wdata;
        end
        r_srt_q <= m_srt[w_srt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd_entry) begin
            m_ent[r_epos] <= {i_cmd.cost, i_cmd.res};
        end
        r_ent_q <= m_ent[w_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd_cap && w_agent_ok) begin
            m_cap[AW'(i_cmd.agent)] <= i_cmd.cap;
        end
        r_cap_q  <= m_cap[w_sc_addr];
        r_capv_q <= r_cap_vld[w_sc_addr];
    end

    assign w_cap_eff = r_capv_q ? r_cap_q : 20'd0;
    assign w_use_eff = r_usev_q ? r_use_q : 20'd0;
    assign w_sum     = {1'b0, w_use_eff} + {5'd0, r_ent_q[15:0]};
    assign w_fit     = (w_sum <= {1'b0, w_cap_eff});
    assign w_tot_sum = {1'b0, r_total} + {17'd0, r_ent_q[31:16]};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHK && w_fit) begin
            m_use[r_agent] <= w_sum[19:0];
        end
        r_use_q  <= m_use[w_sc_addr];
        r_usev_q <= r_use_vld[w_sc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_epos    <= '0;
            r_total   <= '0;
            r_all     <= 1'b1;
            r_jobs    <= '0;
            r_cap_vld <= '0;
            r_use_vld <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_cmd_start) begin
                        r_use_vld <= '0;
                        r_epos    <= '0;
                        r_total   <= '0;
                        r_all     <= 1'b1;
                        r_jobs    <= '0;
                    end
                    if (w_cmd_cap && w_agent_ok) begin
                        r_cap_vld[AW'(i_cmd.agent)] <= 1'b1;
                    end
                    if (w_cmd_entry) begin
                        if (w_last_entry) begin
                            r_epos  <= '0;
                            r_i     <= '0;
                            r_j     <= w_last;
                            r_state <= ST_SCA;
                        end else begin
                            r_epos <= r_epos + AW'(1);
                        end
                    end
                end
                ST_SCA: begin
                    r_state <= ST_SCW;
                end
                ST_SCW: begin
                    if (NW'(r_i) == w_nm1) begin
                        r_i     <= '0;
                        r_state <= (w_nm1 == NW'(0)) ? ST_SRD : ST_JRD;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= ST_SCA;
                    end
                end
                ST_JRD: begin
                    r_k     <= r_j - AW'(1);
                    r_state <= ST_KRD;
                end
                ST_KRD: begin
                    r_held  <= r_srt_q;
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_swap) begin
                        r_held <= r_srt_q;
                    end
                    if (r_k == '0) begin
                        r_state <= ST_JWR;
                    end else begin
                        r_k <= r_k - AW'(1);
                    end
                end
                ST_JWR: begin
                    if (r_j == AW'(1)) begin
                        r_i     <= '0;
                        r_state <= ST_SRD;
                    end else begin
                        r_j     <= r_j - AW'(1);
                        r_state <= ST_JRD;
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SAG;
                end
                ST_SAG: begin
                    r_agent <= w_sc_addr;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (w_fit) begin
                        r_use_vld[r_agent] <= 1'b1;
                        r_total  <= w_tot_sum[32] ? 32'hFFFF_FFFF : w_tot_sum[31:0];
                        r_placed <= 1'b1;
                        r_chosen <= 5'(r_agent);
                        r_state  <= ST_OUT;
                    end else if (NW'(r_i) == w_nm1) begin
                        r_all    <= 1'b0;
                        r_placed <= 1'b0;
                        r_chosen <= 5'd0;
                        r_state  <= ST_OUT;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= ST_SRD;
                    end
                end
                ST_OUT: begin
                    if (i_res_ready) begin
                        r_jobs  <= r_jobs + 16'd1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid       = (r_state == ST_OUT);
    assign o_res.job         = r_jobs;
    assign o_res.assigned    = r_placed;
    assign o_res.chosen      = r_chosen;
    assign o_res.total       = r_total;
    assign o_res.every       = r_all;
    assign o_res.final_cost  = r_all ? r_total : 32'd0;

    a_all_fell_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_all) |-> ($past(r_state) == ST_CHK))
        else $error("all_placed cleared outside a failed scan");

    a_outer_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_JWR) |-> (r_j != '0))
        else $error("sort outer index reached zero");

    a_unassigned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !r_placed) |-> (r_chosen == 5'd0))
        else $error("unassigned job names an agent");

    a_cmp_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |=> (r_state == ST_CMP || r_state == ST_JWR))
        else $error("sort left the inner pass early");

endmodule
`default_nettype wire
